[hdl/dtmf_pkg.sv]
// dtmf_pkg: shared constants, types and functions for the dual-tone sample pipeline.
// Holds the key decoder, the quarter-wave sine table builder and the register codes.
// No dependencies.
`default_nettype none

package dtmf_pkg;

	// sizes of the datapath
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int INDEX_BITS      = 24;

	localparam int KEY_W     = 8;
	localparam int FIELD_W   = 24;
	localparam int SAMPLE_W  = 16;
	localparam int FREQ_W    = 11;
	localparam int RATE_W    = 20;
	localparam int FADE_W    = 12;
	localparam int STEP_W    = 16;
	localparam int AMP_W     = 16;
	localparam int GAIN_W    = 17;
	localparam int MAG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	// quarter-wave table geometry
	localparam int ROM_AW    = SINE_TABLE_BITS - 1;
	localparam int ROM_DEPTH = (1 << (SINE_TABLE_BITS - 2)) + 1;
	localparam logic [SINE_TABLE_BITS-1:0] SINE_HALF    =
		SINE_TABLE_BITS'(1 << (SINE_TABLE_BITS - 1));
	localparam logic [ROM_AW-1:0]          SINE_QUARTER = ROM_AW'(1 << (SINE_TABLE_BITS - 2));

	// unity gain and rounding offset, Q1.16
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
	localparam logic [15:0]       ROUND_HALF = 16'h8000;

	// output limits
	localparam logic [GAIN_W-1:0] POS_LIMIT = 17'd32767;
	localparam logic [GAIN_W-1:0] NEG_LIMIT = 17'd32768;

	// register reset values
	localparam logic [RATE_W-1:0] RATE_RESET = 20'd97391;
	localparam logic [FADE_W-1:0] FADE_RESET = 12'd176;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd372;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd26214;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_RECIPROCAL = 2'd0,
		REG_FADE_LENGTH     = 2'd1,
		REG_FADE_STEP       = 2'd2,
		REG_AMPLITUDE       = 2'd3
	} cfg_reg_t;

	typedef logic [FREQ_W-1:0] freq_t;

	typedef struct packed {
		freq_t row;
		freq_t col;
	} key_freq_t;

	localparam freq_t ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
	localparam freq_t COL_FREQ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

	typedef logic [MAG_W-1:0] sine_rom_t [ROM_DEPTH];

	// keypad character to row and column frequency, zero for anything unknown
	function automatic key_freq_t decode_key(logic [KEY_W-1:0] c);
		key_freq_t f;
		logic       ok;
		logic [1:0] r;
		logic [1:0] q;
		logic [3:0] d;
		ok = 1'b1;
		r  = 2'd0;
		q  = 2'd0;
		d  = 4'(c - "1");
		if (c >= "1" && c <= "9") begin
			r = (d >= 4'd6) ? 2'd2 : ((d >= 4'd3) ? 2'd1 : 2'd0);
			q = 2'(d - 4'(r) * 4'd3);
		end else if (c == "0") begin
			r = 2'd3; q = 2'd1;
		end else if (c == "*") begin
			r = 2'd3; q = 2'd0;
		end else if (c == "#") begin
			r = 2'd3; q = 2'd2;
		end else if (c >= "A" && c <= "D") begin
			r = 2'(c - "A"); q = 2'd3;
		end else if (c >= "a" && c <= "c") begin
			r = 2'd0; q = 2'd1;
		end else if (c >= "d" && c <= "f") begin
			r = 2'd0; q = 2'd2;
		end else if (c >= "g" && c <= "i") begin
			r = 2'd1; q = 2'd0;
		end else if (c >= "j" && c <= "l") begin
			r = 2'd1; q = 2'd1;
		end else if (c >= "m" && c <= "o") begin
			r = 2'd1; q = 2'd2;
		end else if (c >= "p" && c <= "s") begin
			r = 2'd2; q = 2'd0;
		end else if (c >= "t" && c <= "v") begin
			r = 2'd2; q = 2'd1;
		end else if (c >= "w" && c <= "z") begin
			r = 2'd2; q = 2'd2;
		end else begin
			ok = 1'b0;
		end
		f.row = ok ? ROW_FREQ[r] : '0;
		f.col = ok ? COL_FREQ[q] : '0;
		return f;
	endfunction

	// fold a full-cycle table index onto the first quarter wave
	function automatic logic [ROM_AW-1:0] fold_index(logic [SINE_TABLE_BITS-1:0] k);
		logic [ROM_AW-1:0] kk;
		kk = k[ROM_AW-1:0];
		if (kk > SINE_QUARTER) begin
			kk = ROM_AW'(SINE_HALF - {1'b0, kk});
		end
		return kk;
	endfunction

	// sine magnitude of a quarter-wave entry: Taylor series to x^11 in Q30
	function automatic logic [MAG_W-1:0] sine_entry(int unsigned kk);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] one;
		one = 64'd1 << 30;
		x  = (64'(kk) * 64'd6746518852 + (64'd1 << (SINE_TABLE_BITS - 1)))
			>> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = one - x2 / 64'd110;
		t  = one - ((x2 * t) >> 30) / 64'd72;
		t  = one - ((x2 * t) >> 30) / 64'd42;
		t  = one - ((x2 * t) >> 30) / 64'd20;
		t  = one - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		s  = (s + (64'd1 << 14)) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[MAG_W-1:0];
	endfunction

	// whole quarter-wave table, built at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

[hdl/dtmf_ifs.sv]
// dtmf_ifs: valid/ready channel interfaces of the dual-tone sample pipeline.
// Tone requests, sample results and register writes. Depends on dtmf_pkg.
`default_nettype none

interface dtmf_tone_if import dtmf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KEY_W-1:0]     key_code;
	logic [FIELD_W-1:0]   sample_index;
	logic [FIELD_W-1:0]   tone_length;

	modport source (output valid, output key_code, output sample_index,
		output tone_length, input ready);
	modport sink (input valid, input key_code, input sample_index,
		input tone_length, output ready);
endinterface

interface dtmf_sample_if import dtmf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

interface dtmf_cfg_if import dtmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/dtmf_tone_synthesizer.sv]
// dtmf_tone_synthesizer: six-stage pipeline producing one dual-tone sample per request.
// Depends on dtmf_pkg and the channel interfaces in dtmf_ifs.
//
//   channel   dir   handshake      payload
//   cfg       in    valid/ready    index, data (register write)
//   tone      in    valid/ready    key_code, sample_index, tone_length
//   sample    out   valid/ready    sample_value
//
// One request per cycle is taken unless the full pipeline is held by a stalled output.
// The stages, in order, are phase multiply, rate multiply, sine table read, amplitude
// multiply, fade-in multiply and fade-out multiply, one stage each.
// Every stage holds when the next one is full and stalled, so empty stages still fill
// while a finished sample waits. Register writes are always taken.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none

module dtmf_tone_synthesizer import dtmf_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	dtmf_cfg_if.sink      cfg,
	dtmf_tone_if.sink     tone,
	dtmf_sample_if.source sample
);

	localparam int PROD1_W = INDEX_BITS + FREQ_W;
	localparam int PROD2_W = PHASE_BITS + RATE_W;
	localparam int FPROD_W = FADE_W + STEP_W;
	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// configuration registers
	logic [RATE_W-1:0] rate_reciprocal_q;
	logic [FADE_W-1:0] fade_length_q;
	logic [STEP_W-1:0] fade_step_q;
	logic [AMP_W-1:0]  amplitude_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_reciprocal_q <= RATE_RESET;
			fade_length_q     <= FADE_RESET;
			fade_step_q       <= STEP_RESET;
			amplitude_q       <= AMP_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_RATE_RECIPROCAL: rate_reciprocal_q <= cfg.data[RATE_W-1:0];
				REG_FADE_LENGTH:     fade_length_q     <= cfg.data[FADE_W-1:0];
				REG_FADE_STEP:       fade_step_q       <= cfg.data[STEP_W-1:0];
				REG_AMPLITUDE:       amplitude_q       <= cfg.data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valid bits and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6     = !v_s6 || sample.ready;
	assign rdy_s5     = !v_s5 || rdy_s6;
	assign rdy_s4     = !v_s4 || rdy_s5;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign tone.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= tone.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: key decode, index times frequency, fade windows
	key_freq_t              key_freq;
	logic [INDEX_BITS-1:0]  idx;
	logic [INDEX_BITS-1:0]  len;
	logic [INDEX_BITS-1:0]  fl_ext;
	logic [INDEX_BITS-1:0]  fade_start;
	logic [INDEX_BITS-1:0]  fade_offset;
	logic [PROD1_W-1:0]     prod_row;
	logic [PROD1_W-1:0]     prod_col;
	logic                   fin;
	logic                   fout;

	always_comb begin
		key_freq    = decode_key(tone.key_code);
		idx         = tone.sample_index[INDEX_BITS-1:0];
		len         = tone.tone_length[INDEX_BITS-1:0];
		fl_ext      = INDEX_BITS'(fade_length_q);
		fade_start  = len - fl_ext;
		fade_offset = idx - fade_start;
		prod_row    = PROD1_W'(idx) * PROD1_W'(key_freq.row);
		prod_col    = PROD1_W'(idx) * PROD1_W'(key_freq.col);
		fin         = idx < fl_ext;
		fout        = (fade_length_q != '0) && (len >= fl_ext) && (idx >= fade_start)
			&& (idx < len);
	end

	logic [PHASE_BITS-1:0] ph_row_s1, ph_col_s1;
	logic                  fin_s1, fout_s1;
	logic [FADE_W-1:0]     idx_lo_s1, j_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ph_row_s1 <= prod_row[PHASE_BITS-1:0];
			ph_col_s1 <= prod_col[PHASE_BITS-1:0];
			fin_s1    <= fin;
			fout_s1   <= fout;
			idx_lo_s1 <= idx[FADE_W-1:0];
			j_s1      <= fade_offset[FADE_W-1:0];
		end
	end

	// stage 2: rate multiply, fade gains
	logic [PROD2_W-1:0] rate_row, rate_col;
	logic [FPROD_W-1:0] in_prod, out_prod;
	logic [GAIN_W-1:0]  gin, gout;

	always_comb begin
		rate_row = PROD2_W'(ph_row_s1) * PROD2_W'(rate_reciprocal_q);
		rate_col = PROD2_W'(ph_col_s1) * PROD2_W'(rate_reciprocal_q);
		in_prod  = FPROD_W'(idx_lo_s1) * FPROD_W'(fade_step_q);
		out_prod = FPROD_W'(j_s1) * FPROD_W'(fade_step_q);
		gin      = GAIN_ONE;
		gout     = GAIN_ONE;
		if (fin_s1) begin
			gin = (in_prod > FPROD_W'(GAIN_ONE)) ? GAIN_ONE : in_prod[GAIN_W-1:0];
		end
		if (fout_s1) begin
			gout = (out_prod >= FPROD_W'(GAIN_ONE)) ? '0
				: GAIN_W'(GAIN_ONE - out_prod[GAIN_W-1:0]);
		end
	end

	logic [SINE_TABLE_BITS-1:0] k_row_s2, k_col_s2;
	logic [GAIN_W-1:0]          gin_s2, gout_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			k_row_s2 <= rate_row[PHASE_BITS-1 -: SINE_TABLE_BITS];
			k_col_s2 <= rate_col[PHASE_BITS-1 -: SINE_TABLE_BITS];
			gin_s2   <= gin;
			gout_s2  <= gout;
		end
	end

	// stage 3: quarter-wave sine table read with sign restore
	logic [ROM_AW-1:0]    a_row, a_col;
	logic [SAMPLE_W-1:0]  mag_row, mag_col;

	always_comb begin
		a_row   = fold_index(k_row_s2);
		a_col   = fold_index(k_col_s2);
		mag_row = SAMPLE_W'(SINE_ROM[a_row]);
		mag_col = SAMPLE_W'(SINE_ROM[a_col]);
	end

	logic signed [SAMPLE_W-1:0] sin_row_s3, sin_col_s3;
	logic [GAIN_W-1:0]          gin_s3, gout_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sin_row_s3 <= k_row_s2[SINE_TABLE_BITS-1] ? SAMPLE_W'(-mag_row) : mag_row;
			sin_col_s3 <= k_col_s2[SINE_TABLE_BITS-1] ? SAMPLE_W'(-mag_col) : mag_col;
			gin_s3     <= gin_s2;
			gout_s3    <= gout_s2;
		end
	end

	// stage 4: sum, magnitude, amplitude scaling
	logic signed [SAMPLE_W:0] tone_sum;
	logic [SAMPLE_W:0]        sum_mag;
	logic [32:0]              amp_prod;

	always_comb begin
		tone_sum = (SAMPLE_W+1)'(sin_row_s3) + (SAMPLE_W+1)'(sin_col_s3);
		sum_mag  = tone_sum[SAMPLE_W] ? (SAMPLE_W+1)'(-tone_sum) : tone_sum;
		amp_prod = 33'(sum_mag[SAMPLE_W-1:0]) * 33'(amplitude_q) + 33'(ROUND_HALF);
	end

	logic              neg_s4;
	logic [GAIN_W-1:0] m_s4, gin_s4, gout_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			neg_s4  <= tone_sum[SAMPLE_W];
			m_s4    <= amp_prod[32:16];
			gin_s4  <= gin_s3;
			gout_s4 <= gout_s3;
		end
	end

	// stage 5: fade-in gain
	logic [34:0] fin_prod;

	assign fin_prod = 35'(m_s4) * 35'(gin_s4) + 35'(ROUND_HALF);

	logic              neg_s5;
	logic [GAIN_W-1:0] m_s5, gout_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			neg_s5  <= neg_s4;
			m_s5    <= fin_prod[32:16];
			gout_s5 <= gout_s4;
		end
	end

	// stage 6: fade-out gain, saturation to Q1.15
	logic [34:0]                fout_prod;
	logic [GAIN_W-1:0]          m_final;
	logic signed [SAMPLE_W-1:0] sat_value;

	always_comb begin
		fout_prod = 35'(m_s5) * 35'(gout_s5) + 35'(ROUND_HALF);
		m_final   = fout_prod[32:16];
		if (neg_s5) begin
			sat_value = (m_final > NEG_LIMIT) ? SAMPLE_W'(-NEG_LIMIT)
				: SAMPLE_W'(-m_final);
		end else begin
			sat_value = (m_final > POS_LIMIT) ? SAMPLE_W'(POS_LIMIT)
				: m_final[SAMPLE_W-1:0];
		end
	end

	logic signed [SAMPLE_W-1:0] sample_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			sample_s6 <= sat_value;
		end
	end

	assign sample.valid        = v_s6;
	assign sample.sample_value = sample_s6;

`ifndef SYNTHESIS
	// an accepted request always lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tone.valid && tone.ready |=> v_s1)
		else $error("accepted request did not reach stage 1");

	// a stalled middle stage keeps its item and payload
	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rdy_s5 |=> v_s4 && $stable(m_s4) && $stable(neg_s4))
		else $error("stage 4 lost or changed an item under stall");

	// fade gains never exceed unity
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (gin_s2 <= GAIN_ONE) && (gout_s2 <= GAIN_ONE))
		else $error("fade gain above unity");

	// input is refused only when the whole pipeline is full
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tone.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !sample.ready)
		else $error("request refused with a free stage");
`endif

endmodule

`default_nettype wire
